/* rtl/core/tlec_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, request codes and the word store access struct for the
// two-level event channel block. No dependencies.
package tlec_pkg;

  // Geometry. WORD_BITS is a power of two; at least two words are present.
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned NUM_CHANNELS  = 4096;
  localparam int unsigned HANDLED_PORTS = 32;

  localparam int unsigned NUM_WORDS = NUM_CHANNELS / WORD_BITS;
  localparam int unsigned SEL_WORDS = (NUM_WORDS < 64) ? NUM_WORDS : 64;

  localparam int unsigned BIT_W  = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W = $clog2(NUM_WORDS);
  localparam int unsigned SIDX_W = $clog2(SEL_WORDS);

  // Field widths.
  localparam int unsigned PORT_W     = 12;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned HANDLER_W  = 32;
  localparam int unsigned HIDX_W     = $clog2(HANDLER_W);
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_RAISE   = 2'd0,
    REQ_MASK    = 2'd1,
    REQ_UNMASK  = 2'd2,
    REQ_SERVICE = 2'd3
  } req_e;

  // One read and one write port on the pending/mask word store.
  typedef struct packed {
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_pend;
    logic [WORD_BITS-1:0] wr_mask;
  } mem_req_t;

endpackage

/* rtl/core/two_level_event_channel_demux_top.sv */
`timescale 1ns / 1ps
// Top level of the two-level event channel controller: request FSM, selector,
// scan snapshot and output register. Depends on tlec_pkg and tlec_word_store.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request kind
//   (raise, mask, unmask, service next), tdata carries the port number.
//   Every request yields exactly one result transaction on m_axis. Write the
//   handler-present bitmap over the cfg channel (always ready) while idle.
// Sequencing:
//   Raise, mask and unmask pass through accept, a read-modify-write of one
//   store word and the output load. A service request reads and evaluates
//   each snapshot word it visits in turn, one store read and one evaluation
//   each, plus one more scan step when the scan runs out of words and ends.
//   Words whose events are masked again get dropped on the way; one request is in flight.
// Reset:
//   All ports come up masked, nothing pending, selector, snapshot, scan and
//   upcall flag clear, no handlers. Store entries carry valid bits, so no
//   clearing pass is needed and the block is ready right after reset.
// Back-pressure:
//   Results sit in an output register. While it holds a result the next
//   request is still accepted and processed; the FSM only waits at its end
//   for the register to free up.
module two_level_event_channel_demux_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Requests. tuser: [1:0] req_type. tdata: [11:0] port, [15:12] zero.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [tlec_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [tlec_pkg::REQ_W-1:0]      s_axis_tuser_i,
  // Results. tdata: [11:0] event_port, [12] event_valid, [13] handled,
  // [14] scan_done, [15] upcall_pending.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [tlec_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // Handler-present register write.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tlec_pkg::HANDLER_W-1:0]  cfg_data_i
);

  localparam int unsigned WB = tlec_pkg::WORD_BITS;
  localparam int unsigned SW = tlec_pkg::SEL_WORDS;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MOD  = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_EVAL = 6'b001000,
    ST_OUT  = 6'b010000,
    ST_WAIT = 6'b100000
  } state_e;

  function automatic logic [tlec_pkg::BIT_W-1:0] lowest_bit(input logic [WB-1:0] v);
    logic [tlec_pkg::BIT_W-1:0] idx;
    idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (v[i]) idx = tlec_pkg::BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [tlec_pkg::SIDX_W-1:0] lowest_sel(input logic [SW-1:0] v);
    logic [tlec_pkg::SIDX_W-1:0] idx;
    idx = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      if (v[i]) idx = tlec_pkg::SIDX_W'(i);
    end
    return idx;
  endfunction

  state_e                         state_q, state_d;
  tlec_pkg::req_e                 req_q, req_d;
  logic [tlec_pkg::PORT_W-1:0]    port_q, port_d;
  logic [tlec_pkg::WIDX_W-1:0]    word_q, word_d;
  logic                           check_q, check_d;   // post-delivery lookahead
  logic [SW-1:0]                  selector_q, selector_d;
  logic [SW-1:0]                  snapshot_q, snapshot_d;
  logic                           scan_active_q, scan_active_d;
  logic                           upcall_q, upcall_d;
  logic [tlec_pkg::HANDLER_W-1:0] handler_q;
  logic [tlec_pkg::PORT_W-1:0]    ev_port_q, ev_port_d;
  logic                           ev_valid_q, ev_valid_d;
  logic                           handled_q, handled_d;
  logic                           m_valid_q, m_valid_d;
  logic [tlec_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

  tlec_pkg::mem_req_t             mem_req;
  logic [WB-1:0]                  rd_pend, rd_mask;

  // Request decode helpers.
  logic                           s_fire;
  tlec_pkg::req_e                 in_req;
  logic [tlec_pkg::PORT_W-1:0]    in_port;
  logic                           port_ok;
  logic [tlec_pkg::WIDX_W-1:0]    port_word;
  logic [WB-1:0]                  port_bit;
  logic                           word_in_sel;
  logic [WB-1:0]                  live, live_rest, dbit;
  logic [tlec_pkg::BIT_W-1:0]     dbit_idx;
  logic [tlec_pkg::PORT_W-1:0]    deliver_port;
  logic                           out_free;

  tlec_word_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_pend_o (rd_pend),
    .rd_mask_o (rd_mask)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_req          = tlec_pkg::req_e'(s_axis_tuser_i);
  assign in_port         = s_axis_tdata_i[tlec_pkg::PORT_W-1:0];
  assign cfg_ready_o     = 1'b1;

  assign port_ok   = {1'b0, port_q} < (tlec_pkg::PORT_W + 1)'(tlec_pkg::NUM_CHANNELS);
  assign port_word = tlec_pkg::WIDX_W'(port_q >> tlec_pkg::BIT_W);
  assign port_bit  = WB'(1) << port_q[tlec_pkg::BIT_W-1:0];
  assign word_in_sel = {1'b0, word_q} < (tlec_pkg::WIDX_W + 1)'(SW);

  assign live         = rd_pend & ~rd_mask;
  assign dbit_idx     = lowest_bit(live);
  assign dbit         = WB'(1) << dbit_idx;
  assign live_rest    = live & ~dbit;
  assign deliver_port = tlec_pkg::PORT_W'({word_q, dbit_idx});
  assign out_free     = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    port_d        = port_q;
    word_d        = word_q;
    check_d       = check_q;
    selector_d    = selector_q;
    snapshot_d    = snapshot_q;
    scan_active_d = scan_active_q;
    upcall_d      = upcall_q;
    ev_port_d     = ev_port_q;
    ev_valid_d    = ev_valid_q;
    handled_d     = handled_q;
    m_valid_d     = m_valid_q && !m_axis_tready_i;
    m_data_d      = m_data_q;
    mem_req       = '0;
    mem_req.wr_pend = rd_pend;
    mem_req.wr_mask = rd_mask;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          req_d      = in_req;
          port_d     = in_port;
          ev_port_d  = '0;
          ev_valid_d = 1'b0;
          handled_d  = 1'b0;
          check_d    = 1'b0;
          if (in_req == tlec_pkg::REQ_SERVICE) begin
            // Start a new scan from the selector unless one is running.
            if (!scan_active_q) begin
              upcall_d      = 1'b0;
              snapshot_d    = selector_q;
              selector_d    = '0;
              scan_active_d = 1'b1;
            end
            state_d = ST_SCAN;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = tlec_pkg::WIDX_W'(in_port >> tlec_pkg::BIT_W);
            word_d          = tlec_pkg::WIDX_W'(in_port >> tlec_pkg::BIT_W);
            state_d         = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        // Read-modify-write of the addressed word; out-of-range ports drop.
        mem_req.wr_en   = port_ok;
        mem_req.wr_addr = port_word;
        case (req_q)
          tlec_pkg::REQ_RAISE: begin
            if ((rd_pend & port_bit) == '0) begin
              mem_req.wr_pend = rd_pend | port_bit;
              if (port_ok && (rd_mask & port_bit) == '0 && word_in_sel &&
                  !selector_q[word_q[tlec_pkg::SIDX_W-1:0]]) begin
                selector_d[word_q[tlec_pkg::SIDX_W-1:0]] = 1'b1;
                upcall_d = 1'b1;
              end
            end
          end
          tlec_pkg::REQ_MASK: begin
            mem_req.wr_mask = rd_mask | port_bit;
          end
          default: begin
            mem_req.wr_mask = rd_mask & ~port_bit;
            if (port_ok && (rd_pend & port_bit) != '0 && word_in_sel &&
                !selector_q[word_q[tlec_pkg::SIDX_W-1:0]]) begin
              selector_d[word_q[tlec_pkg::SIDX_W-1:0]] = 1'b1;
              upcall_d = 1'b1;
            end
          end
        endcase
        state_d = ST_OUT;
      end

      ST_SCAN: begin
        if (snapshot_q == '0) begin
          // Nothing left to visit: end the scan.
          scan_active_d = 1'b0;
          state_d       = ST_OUT;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = tlec_pkg::WIDX_W'(lowest_sel(snapshot_q));
          word_d          = tlec_pkg::WIDX_W'(lowest_sel(snapshot_q));
          state_d         = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (live == '0) begin
          // Drop a word that holds no unmasked pending event.
          snapshot_d[word_q[tlec_pkg::SIDX_W-1:0]] = 1'b0;
          state_d = ST_SCAN;
        end else if (check_q) begin
          state_d = ST_OUT;
        end else begin
          // Deliver the lowest live port and clear its pending bit.
          ev_port_d  = deliver_port;
          ev_valid_d = 1'b1;
          handled_d  = (deliver_port < tlec_pkg::PORT_W'(tlec_pkg::HANDLED_PORTS)) &&
                       (deliver_port < tlec_pkg::PORT_W'(tlec_pkg::HANDLER_W)) &&
                       handler_q[deliver_port[tlec_pkg::HIDX_W-1:0]];
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = word_q;
          mem_req.wr_pend = rd_pend & ~dbit;
          if (live_rest != '0) begin
            state_d = ST_OUT;
          end else begin
            snapshot_d[word_q[tlec_pkg::SIDX_W-1:0]] = 1'b0;
            check_d = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end

      ST_OUT, ST_WAIT: begin
        // Hold the result until the output register frees up.
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {upcall_q, !scan_active_q, handled_q, ev_valid_q, ev_port_q};
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_WAIT;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      selector_q    <= '0;
      snapshot_q    <= '0;
      scan_active_q <= 1'b0;
      upcall_q      <= 1'b0;
      handler_q     <= '0;
      m_valid_q     <= 1'b0;
      check_q       <= 1'b0;
    end else begin
      state_q       <= state_d;
      selector_q    <= selector_d;
      snapshot_q    <= snapshot_d;
      scan_active_q <= scan_active_d;
      upcall_q      <= upcall_d;
      m_valid_q     <= m_valid_d;
      check_q       <= check_d;
      if (cfg_valid_i && cfg_ready_o) begin
        handler_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    port_q     <= port_d;
    word_q     <= word_d;
    ev_port_q  <= ev_port_d;
    ev_valid_q <= ev_valid_d;
    handled_q  <= handled_d;
    m_data_q   <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // The upcall flag is raised exactly when a selector bit gets set and both
  // clear together at scan start.
  a_upcall_tracks_selector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upcall_q == (selector_q != '0))
    else $error("upcall flag out of step with word selector");

  // Snapshot words survive only while a scan is running.
  a_snapshot_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !scan_active_q |-> snapshot_q == '0)
    else $error("scan snapshot non-empty with no active scan");

  // A handled flag is only ever reported with a delivered port.
  a_handled_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[13] |-> m_axis_tdata_o[12])
    else $error("handled result without a delivered event");

  // A finished request reaches the output register once it is free.
  a_out_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT || state_q == ST_WAIT) && out_free |=> m_axis_tvalid_o)
    else $error("result not loaded into output register");

endmodule

/* rtl/core/tlec_word_store.sv */
`timescale 1ns / 1ps
// Word store: pending and mask words side by side in one synchronous memory,
// with registered read data. Depends on tlec_pkg.
module tlec_word_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tlec_pkg::mem_req_t             req_i,
  output logic [tlec_pkg::WORD_BITS-1:0] rd_pend_o,
  output logic [tlec_pkg::WORD_BITS-1:0] rd_mask_o
);

  logic [2*tlec_pkg::WORD_BITS-1:0] mem [tlec_pkg::NUM_WORDS];
  logic [2*tlec_pkg::WORD_BITS-1:0] rd_data_q;
  logic [tlec_pkg::NUM_WORDS-1:0]   vld_q;
  logic                             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= {req_i.wr_mask, req_i.wr_pend};
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  // Entry never written reads as its reset value: nothing pending, all masked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_pend_o = rd_vld_q ? rd_data_q[tlec_pkg::WORD_BITS-1:0] : '0;
  assign rd_mask_o = rd_vld_q ? rd_data_q[2*tlec_pkg::WORD_BITS-1:tlec_pkg::WORD_BITS] : '1;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for two_level_event_channel_demux_top: a scoreboard
// class predicts every result transaction from accepted requests and handler
// writes. Depends on tlec_pkg and the block's RTL.
module tb;

  localparam int unsigned PORT_W        = tlec_pkg::PORT_W;
  localparam int unsigned REQ_W         = tlec_pkg::REQ_W;
  localparam int unsigned WORD_BITS     = tlec_pkg::WORD_BITS;
  localparam int unsigned NUM_WORDS     = tlec_pkg::NUM_WORDS;
  localparam int unsigned SEL_WORDS     = tlec_pkg::SEL_WORDS;
  localparam int unsigned NUM_CHANNELS  = tlec_pkg::NUM_CHANNELS;
  localparam int unsigned HANDLED_PORTS = tlec_pkg::HANDLED_PORTS;
  localparam int unsigned HANDLER_W     = tlec_pkg::HANDLER_W;
  localparam int unsigned IN_DATA_W     = tlec_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W    = tlec_pkg::OUT_DATA_W;

  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS = 245;
  localparam int unsigned NUM_PHASES  = 5;

  typedef struct {
    logic [PORT_W-1:0] ev_port;
    logic              ev_valid;
    logic              handled;
    logic              scan_done;
    logic              upcall;
  } outcome_t;

  // Track pending/mask words, selector, scan snapshot and upcall flag, and
  // hold the outcome each accepted request is due to produce.
  class tlec_event_scoreboard;
    logic [WORD_BITS-1:0] pend_words [NUM_WORDS];
    logic [WORD_BITS-1:0] mask_words [NUM_WORDS];
    logic [SEL_WORDS-1:0] selector;
    logic [SEL_WORDS-1:0] snapshot;
    bit                   scanning;
    bit                   upcall;
    logic [HANDLER_W-1:0] handlers;
    outcome_t             due_outcomes[$];
    int unsigned          mismatches;

    function new();
      for (int w = 0; w < NUM_WORDS; w++) begin
        pend_words[w] = '0;
        mask_words[w] = '1;
      end
      selector   = '0;
      snapshot   = '0;
      scanning   = 0;
      upcall     = 0;
      handlers   = '0;
      mismatches = 0;
    endfunction

    function void set_handlers(logic [HANDLER_W-1:0] value);
      handlers = value;
    endfunction

    function int unsigned outstanding();
      return due_outcomes.size();
    endfunction

    // Flag the word in the selector; the first flag raises the upcall.
    function void mark_word(int unsigned w);
      if (w >= SEL_WORDS) return;
      if (!selector[w]) begin
        selector[w] = 1'b1;
        upcall      = 1'b1;
      end
    endfunction

    // Drop snapshot words with nothing deliverable; return the lowest live one.
    function int live_word();
      for (int w = 0; w < SEL_WORDS; w++) begin
        if (snapshot[w]) begin
          if ((pend_words[w] & ~mask_words[w]) != '0) return w;
          snapshot[w] = 1'b0;
        end
      end
      snapshot = '0;
      return -1;
    endfunction

    function void note_request(tlec_pkg::req_e req, logic [PORT_W-1:0] port);
      outcome_t             res;
      int unsigned          w;
      int unsigned          b;
      int                   lw;
      logic [WORD_BITS-1:0] live;
      int unsigned          pos;
      res = '{default: '0};
      w   = port / WORD_BITS;
      b   = port % WORD_BITS;
      if (req != tlec_pkg::REQ_SERVICE) begin
        if (port < NUM_CHANNELS) begin
          case (req)
            tlec_pkg::REQ_RAISE: begin
              if (!pend_words[w][b]) begin
                pend_words[w][b] = 1'b1;
                if (!mask_words[w][b]) mark_word(w);
              end
            end
            tlec_pkg::REQ_MASK: begin
              mask_words[w][b] = 1'b1;
            end
            default: begin
              mask_words[w][b] = 1'b0;
              if (pend_words[w][b]) mark_word(w);
            end
          endcase
        end
      end else begin
        if (!scanning) begin
          upcall   = 1'b0;
          snapshot = selector;
          selector = '0;
          scanning = 1'b1;
        end
        lw = live_word();
        if (lw >= 0) begin
          live = pend_words[lw] & ~mask_words[lw];
          pos  = 0;
          while (pos < WORD_BITS - 1 && !live[pos]) pos++;
          res.ev_port  = PORT_W'(lw * WORD_BITS + pos);
          res.ev_valid = 1'b1;
          res.handled  = (res.ev_port < HANDLED_PORTS) && (res.ev_port < 32) &&
                         handlers[res.ev_port[4:0]];
          pend_words[lw][pos] = 1'b0;
          lw = live_word();
        end
        if (lw < 0) scanning = 1'b0;
      end
      res.scan_done = !scanning;
      res.upcall    = upcall;
      due_outcomes.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] expv, logic [15:0] actv);
      if (actv !== expv) begin
        $error("%s: expected %0d, got %0d", name, expv, actv);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      outcome_t due;
      if (due_outcomes.size() == 0) begin
        $error("result transaction with nothing due: tdata %h", data);
        mismatches++;
        return;
      end
      due = due_outcomes.pop_front();
      compare_field("event_port", 16'(due.ev_port), 16'(data[11:0]));
      compare_field("event_valid", 16'(due.ev_valid), 16'(data[12]));
      compare_field("handled", 16'(due.handled), 16'(data[13]));
      compare_field("scan_done", 16'(due.scan_done), 16'(data[14]));
      compare_field("upcall_pending", 16'(due.upcall), 16'(data[15]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [HANDLER_W-1:0]  cfg_data = '0;

  tlec_event_scoreboard sb = new();
  bit                   steady_flow = 0;  // no idling on either side
  int unsigned          stall_left = 0;
  int unsigned          idle_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  two_level_event_channel_demux_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Favor low (handler) ports and a few hot words; leave a quarter fully random.
  function automatic logic [PORT_W-1:0] pick_port();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return PORT_W'($urandom_range(0, 31));
    if (r < 60) return PORT_W'($urandom_range(WORD_BITS, 3 * WORD_BITS - 1));
    if (r < 75) return PORT_W'($urandom_range(NUM_CHANNELS - WORD_BITS, NUM_CHANNELS - 1));
    return PORT_W'($urandom_range(0, NUM_CHANNELS - 1));
  endfunction

  // Drive one request transaction and note it once accepted.
  task automatic send_request(tlec_pkg::req_e req, logic [PORT_W-1:0] port);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= IN_DATA_W'(port);
    do @(posedge clk_i); while (!s_tready);
    sb.note_request(req, port);
  endtask

  // Drop valid and hold until every due result has come back.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  task automatic write_handlers(logic [HANDLER_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_handlers(value);
  endtask

  // Result side: check each accepted transaction, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready   <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("two_level_event_channel_demux_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned          r;
    logic [HANDLER_W-1:0] hval;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: port 0 and 31 have handlers, port 1 does not.
    write_handlers(32'h8000_0001);
    send_request(tlec_pkg::REQ_SERVICE, 12'd0);     // nothing pending
    send_request(tlec_pkg::REQ_RAISE, 12'd0);       // masked raise: pending only
    send_request(tlec_pkg::REQ_UNMASK, 12'd0);      // unmask re-raises, upcall
    send_request(tlec_pkg::REQ_SERVICE, 12'd0);     // deliver port 0, handled
    send_request(tlec_pkg::REQ_UNMASK, 12'd31);
    send_request(tlec_pkg::REQ_RAISE, 12'd31);
    send_request(tlec_pkg::REQ_RAISE, 12'd31);      // already pending: no change
    send_request(tlec_pkg::REQ_UNMASK, 12'd1);
    send_request(tlec_pkg::REQ_RAISE, 12'd1);       // word already in selector
    send_request(tlec_pkg::REQ_RAISE, 12'd4095);
    send_request(tlec_pkg::REQ_UNMASK, 12'd4095);   // top word into selector
    send_request(tlec_pkg::REQ_MASK, 12'd1);        // masked after selection: skipped
    send_request(tlec_pkg::REQ_SERVICE, 12'd0);     // port 31, scan continues
    send_request(tlec_pkg::REQ_UNMASK, 12'd64);
    send_request(tlec_pkg::REQ_RAISE, 12'd64);      // new selector bit mid-scan
    send_request(tlec_pkg::REQ_SERVICE, 12'd0);     // port 4095, scan ends
    send_request(tlec_pkg::REQ_SERVICE, 12'd0);     // fresh scan: port 64
    send_request(tlec_pkg::REQ_UNMASK, 12'd2048);
    send_request(tlec_pkg::REQ_RAISE, 12'd2048);
    send_request(tlec_pkg::REQ_UNMASK, 12'd4094);
    send_request(tlec_pkg::REQ_RAISE, 12'd4094);
    send_request(tlec_pkg::REQ_MASK, 12'd4094);     // top word goes dead before scan
    send_request(tlec_pkg::REQ_SERVICE, 12'd0);     // port 2048, dead word dropped
    send_request(tlec_pkg::REQ_UNMASK, 12'd1);      // port 1 still pending: re-raise
    send_request(tlec_pkg::REQ_SERVICE, 12'd0);     // port 1, no handler
    send_request(tlec_pkg::REQ_SERVICE, 12'd0);     // empty again

    // Random phases, each with its own handler setting.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      hold_until_drained();
      case (phase)
        0:       hval = '0;
        1:       hval = '1;
        4:       hval = 32'h8000_0001;
        default: hval = $urandom;
      endcase
      write_handlers(hval);
      steady_flow = (phase == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 1 && i == PHASE_ITEMS / 2) hold_until_drained();
        r = $urandom_range(0, 99);
        if (r < 30)      send_request(tlec_pkg::REQ_RAISE, pick_port());
        else if (r < 46) send_request(tlec_pkg::REQ_UNMASK, pick_port());
        else if (r < 54) send_request(tlec_pkg::REQ_MASK, pick_port());
        else             send_request(tlec_pkg::REQ_SERVICE,
                                      PORT_W'($urandom_range(0, NUM_CHANNELS - 1)));
      end
    end
    steady_flow = 0;

    // Drain, then give a stray late result time to show up.
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("two_level_event_channel_demux_top regression: pass");
    end else begin
      $display("two_level_event_channel_demux_top regression: fail");
    end
    $finish;
  end

endmodule
